FILE: src/dosr_pkg.sv
`default_nettype none

package dosr_pkg;

	localparam int unsigned RING_DEPTH_DEF = 64;

	localparam int unsigned SEQ_W    = 64;
	localparam int unsigned TS_W     = 64;
	localparam int unsigned MASK_W   = 2;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CNT64_W  = 64;
	localparam int unsigned FILL_W   = 7;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  sequence_num;
		logic [TS_W-1:0]   timestamp;
		logic [MASK_W-1:0] mask;
		logic [WORD_W-1:0] voltage;
		logic [WORD_W-1:0] current;
	} sample_t;

endpackage

`default_nettype wire

FILE: src/drop_oldest_sample_ring.sv
// Channel  Direction  Handshake             Payload
// in       request    in_valid / in_stall   cmd, in_sequence, in_timestamp, in_mask,
//                                           in_voltage, in_current
// out      response   out_valid / out_stall dropped, pop_ok, out_sequence, out_timestamp,
//                                           out_mask, out_voltage, out_current,
//                                           overflow_before, drop_total, fill_level
//
// One command per cycle unless out_stall backs up; results pass stage 1, then stage 2.
// The single read port of the sample RAM (registered read) is why there are two stages.
// Reset clears head, count, drop counter and overflow flag; ring contents are not cleared.
// out_stall holds the result register; once the middle stage is also full, in_stall rises.
`default_nettype none

module drop_oldest_sample_ring
	import dosr_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          cmd,
	input  wire logic [SEQ_W-1:0]    in_sequence,
	input  wire logic [TS_W-1:0]     in_timestamp,
	input  wire logic [MASK_W-1:0]   in_mask,
	input  wire logic [WORD_W-1:0]   in_voltage,
	input  wire logic [WORD_W-1:0]   in_current,

	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     dropped,
	output logic                     pop_ok,
	output logic      [SEQ_W-1:0]    out_sequence,
	output logic      [TS_W-1:0]     out_timestamp,
	output logic      [MASK_W-1:0]   out_mask,
	output logic      [WORD_W-1:0]   out_voltage,
	output logic      [WORD_W-1:0]   out_current,
	output logic                     overflow_before,
	output logic      [CNT64_W-1:0]  drop_total,
	output logic      [FILL_W-1:0]   fill_level
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam int unsigned CW = $clog2(RING_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(RING_DEPTH);
	localparam logic [AW:0]   DEPTH_X   = (AW+1)'(RING_DEPTH);

	// control state
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [CNT64_W-1:0] drop_q;
	logic               pend_q;

	logic [AW-1:0]      head_d;
	logic [CW-1:0]      count_d;
	logic [CNT64_W-1:0] drop_d;
	logic               pend_d;

	logic               accept;
	logic               adv_s1;
	logic               full;
	logic [AW-1:0]      head_inc;
	logic [AW:0]        tail_sum;
	logic [AW-1:0]      tail;
	logic [AW-1:0]      wr_addr;
	logic               push_w;
	logic               read_w;
	logic               drop_w;
	logic               popok_w;
	logic               ovf_w;

	sample_t            wr_sample;
	sample_t            rd_sample;

	// stage 1: status of the command, RAM read data lines up with it
	logic               valid_s1;
	logic               dropped_s1;
	logic               popok_s1;
	logic               ovf_s1;
	logic [CNT64_W-1:0] total_s1;
	logic [FILL_W-1:0]  fill_s1;

	// stage 2: result register
	logic               valid_s2;
	logic               dropped_s2;
	logic               popok_s2;
	sample_t            sample_s2;
	logic               ovf_s2;
	logic [CNT64_W-1:0] total_s2;
	logic [FILL_W-1:0]  fill_s2;

	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	assign full     = (count_q == FULL_CNT);
	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign tail_sum = {1'b0, head_q} + (AW+1)'(count_q);
	assign tail     = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
	// a full ring overwrites the head slot
	assign wr_addr  = full ? head_q : tail;

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		drop_d  = drop_q;
		pend_d  = pend_q;
		push_w  = 1'b0;
		read_w  = 1'b0;
		drop_w  = 1'b0;
		popok_w = 1'b0;
		ovf_w   = 1'b0;
		case (cmd_t'(cmd))
			CMD_PUSH: begin
				push_w = 1'b1;
				if (full) begin
					head_d = head_inc;
					drop_w = 1'b1;
					pend_d = 1'b1;
					if (drop_q != '1) begin
						drop_d = drop_q + 1'b1;
					end
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP: begin
				if (count_q != '0) begin
					read_w  = 1'b1;
					popok_w = 1'b1;
					ovf_w   = pend_q;
					head_d  = head_inc;
					count_d = count_q - 1'b1;
					pend_d  = 1'b0;
				end
			end
			CMD_CLEAR: begin
				head_d  = '0;
				count_d = '0;
				pend_d  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign wr_sample = '{sequence_num: in_sequence, timestamp: in_timestamp,
		mask: in_mask, voltage: in_voltage, current: in_current};

	dosr_ram #(
		.WIDTH ($bits(sample_t)),
		.DEPTH (RING_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (accept && push_w),
		.wr_addr (wr_addr),
		.wr_data (wr_sample),
		.rd_en   (accept && read_w),
		.rd_addr (head_q),
		.rd_data (rd_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			drop_q  <= '0;
			pend_q  <= 1'b0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
			drop_q  <= drop_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dropped_s1 <= drop_w;
			popok_s1   <= popok_w;
			ovf_s1     <= ovf_w;
			total_s1   <= drop_d;
			fill_s1    <= FILL_W'(count_d);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			dropped_s2 <= dropped_s1;
			popok_s2   <= popok_s1;
			sample_s2  <= popok_s1 ? rd_sample : '0;
			ovf_s2     <= ovf_s1;
			total_s2   <= total_s1;
			fill_s2    <= fill_s1;
		end
	end

	assign out_valid       = valid_s2;
	assign dropped         = dropped_s2;
	assign pop_ok          = popok_s2;
	assign out_sequence    = sample_s2.sequence_num;
	assign out_timestamp   = sample_s2.timestamp;
	assign out_mask        = sample_s2.mask;
	assign out_voltage     = sample_s2.voltage;
	assign out_current     = sample_s2.current;
	assign overflow_before = ovf_s2;
	assign drop_total      = total_s2;
	assign fill_level      = fill_s2;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above ring depth");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free stage");

	a_full_push_stays_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_PUSH && full) |=> (full && pend_q))
		else $error("push into full ring lost fill or overflow flag");

	a_drop_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (drop_q >= $past(drop_q)))
		else $error("drop counter went backwards");

	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!accept || cmd != CMD_PUSH || !full) |=> $stable(drop_q))
		else $error("drop counter changed without a drop");
`endif

endmodule

`default_nettype wire

FILE: src/dosr_ram.sv
`default_nettype none

module dosr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire
